[hw/rtl/hpt_pkg.sv]
// shared types, fixed-point constants and helpers of the height-map point transform
`default_nettype none

package hpt_pkg;

	// one 32-bit wrapped coordinate
	typedef logic signed [31:0] hpt_coord_t;

	// configuration register indexes
	localparam logic [3:0] CFG_ZOOM   = 4'd0;
	localparam logic [3:0] CFG_HSCALE = 4'd1;
	localparam logic [3:0] CFG_GRID   = 4'd2;
	localparam logic [3:0] CFG_TRIG_X = 4'd3;
	localparam logic [3:0] CFG_TRIG_Y = 4'd4;
	localparam logic [3:0] CFG_TRIG_Z = 4'd5;
	localparam logic [3:0] CFG_ISO    = 4'd6;
	localparam logic [3:0] CFG_PAN    = 4'd7;

	// exact product sums are held at this width before scaling
	localparam int SUM_W = 50;

	// fractional bits of the Q2.14 trig factors
	localparam int Q_FRAC = 14;
	localparam logic signed [SUM_W-1:0] Q_BIAS = SUM_W'((1 << Q_FRAC) - 1);

	// divide by 2^14 truncating toward zero, keep the low 32 bits
	function automatic hpt_coord_t q14_trunc(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] biased;
		biased = v + (v[SUM_W-1] ? Q_BIAS : '0);
		return biased[Q_FRAC+31:Q_FRAC];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/hpt_front.sv]
// front end: scaling of column, row and height, grid centring
`default_nettype none

module hpt_front import hpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [11:0]        column,
	input  wire logic [11:0]        row,
	input  wire logic signed [15:0] height_value,
	input  wire logic [9:0]         zoom,
	input  wire logic signed [8:0]  height_scale,
	input  wire logic [31:0]        grid_dims,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      hpt_coord_t         x_cen,
	output      hpt_coord_t         y_cen,
	output      hpt_coord_t         z_scaled
);

	logic v_s1, v_s2;
	logic rdy_s1, rdy_s2;

	logic [21:0]        x_s1, y_s1;
	logic signed [24:0] z_s1;
	logic signed [27:0] cw_s1, ch_s1;
	hpt_coord_t         xc_s2, yc_s2, z_s2;

	logic signed [16:0] dim_w_m1, dim_h_m1;
	logic signed [26:0] half_w, half_h;

	// halve toward zero
	function automatic logic signed [26:0] half_trunc(input logic signed [27:0] v);
		logic [27:0] biased;
		biased = v + 28'(v[27]);
		return biased[27:1];
	endfunction

	// stage handshake, bubbles collapse
	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// grid dimension minus one, a zero dimension gives minus one
	assign dim_w_m1 = $signed({1'b0, grid_dims[31:16]}) - 17'sd1;
	assign dim_h_m1 = $signed({1'b0, grid_dims[15:0]}) - 17'sd1;
	assign half_w   = half_trunc(cw_s1);
	assign half_h   = half_trunc(ch_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// stage 1: scale products and centring products
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			x_s1  <= 22'(column) * 22'(zoom);
			y_s1  <= 22'(row) * 22'(zoom);
			z_s1  <= 25'(height_value) * 25'(height_scale);
			cw_s1 <= 28'($signed({1'b0, zoom})) * 28'(dim_w_m1);
			ch_s1 <= 28'($signed({1'b0, zoom})) * 28'(dim_h_m1);
		end
	end

	// stage 2: subtract the centring terms
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			xc_s2 <= {10'b0, x_s1} - {{5{half_w[26]}}, half_w};
			yc_s2 <= {10'b0, y_s1} - {{5{half_h[26]}}, half_h};
			z_s2  <= {{7{z_s1[24]}}, z_s1};
		end
	end

	assign out_valid = v_s2;
	assign x_cen     = xc_s2;
	assign y_cen     = yc_s2;
	assign z_scaled  = z_s2;

endmodule

`default_nettype wire

[hw/rtl/hpt_rot.sv]
// one plane rotation in Q2.14: products stage, then sum and truncation stage
`default_nettype none

module hpt_rot import hpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire hpt_coord_t         a,
	input  wire hpt_coord_t         b,
	input  wire hpt_coord_t         pass,
	input  wire logic signed [15:0] cos_q14,
	input  wire logic signed [16:0] sin_q14,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      hpt_coord_t         a_rot,
	output      hpt_coord_t         b_rot,
	output      hpt_coord_t         pass_out
);

	// width of one exact product
	localparam int PROD_W = SUM_W - 1;

	logic v_s1, v_s2;
	logic rdy_s1, rdy_s2;

	logic signed [SUM_W-2:0] p_ac_s1, p_bs_s1, p_as_s1, p_bc_s1;
	hpt_coord_t              pass_s1;
	hpt_coord_t              a_s2, b_s2, pass_s2;

	logic signed [SUM_W-1:0] sum_a, sum_b;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// stage 1: four products
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			p_ac_s1 <= PROD_W'(a) * PROD_W'(cos_q14);
			p_bs_s1 <= PROD_W'(b) * PROD_W'(sin_q14);
			p_as_s1 <= PROD_W'(a) * PROD_W'(sin_q14);
			p_bc_s1 <= PROD_W'(b) * PROD_W'(cos_q14);
			pass_s1 <= pass;
		end
	end

	// a' = a*c + b*s, b' = b*c - a*s, exact
	assign sum_a = {p_ac_s1[SUM_W-2], p_ac_s1} + {p_bs_s1[SUM_W-2], p_bs_s1};
	assign sum_b = {p_bc_s1[SUM_W-2], p_bc_s1} - {p_as_s1[SUM_W-2], p_as_s1};

	// stage 2: scale back and wrap
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			a_s2    <= q14_trunc(sum_a);
			b_s2    <= q14_trunc(sum_b);
			pass_s2 <= pass_s1;
		end
	end

	assign out_valid = v_s2;
	assign a_rot     = a_s2;
	assign b_rot     = b_s2;
	assign pass_out  = pass_s2;

endmodule

`default_nettype wire

[hw/rtl/hpt_proj.sv]
// isometric projection and screen pan, three stages ending in the output register
`default_nettype none

module hpt_proj import hpt_pkg::*; #(
	parameter int SCREEN_WIDTH  = 1920,
	parameter int SCREEN_HEIGHT = 1080
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire hpt_coord_t  x,
	input  wire hpt_coord_t  y,
	input  wire hpt_coord_t  z,
	input  wire logic        iso_enable,
	input  wire logic [31:0] pan_offsets,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      hpt_coord_t  screen_x,
	output      hpt_coord_t  screen_y,
	output      hpt_coord_t  depth_z
);

	localparam logic [31:0]        HALF_W  = 32'(SCREEN_WIDTH / 2);
	localparam logic [31:0]        HALF_H  = 32'(SCREEN_HEIGHT / 2);
	// cos 30 degrees in Q2.14
	localparam logic signed [15:0] ISO_COS = 16'sd14189;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	hpt_coord_t              x_s1, y_s1, z_s1, d_s1, s_s1;
	hpt_coord_t              x_s2, y_s2, z_s2, shalf_s2;
	logic signed [46:0]      prod_s2;
	hpt_coord_t              sx_s3, sy_s3, z_s3;

	logic [31:0] s_biased;
	hpt_coord_t  s_half;
	hpt_coord_t  x_sel, y_sel;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: difference and sum of x and y
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			x_s1 <= x;
			y_s1 <= y;
			z_s1 <= z;
			d_s1 <= x - y;
			s_s1 <= x + y;
		end
	end

	// sum times sin 30 degrees is the sum halved toward zero
	assign s_biased = s_s1 + {31'b0, s_s1[31]};
	assign s_half   = {s_biased[31], s_biased[31:1]};

	// stage 2: cos 30 product
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			prod_s2  <= 47'(d_s1) * 47'(ISO_COS);
			shalf_s2 <= s_half;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
		end
	end

	// projection or bypass
	assign x_sel = iso_enable ? q14_trunc({{(SUM_W-47){prod_s2[46]}}, prod_s2}) : x_s2;
	assign y_sel = iso_enable ? (shalf_s2 - z_s2) : y_s2;

	// stage 3: pan to screen centre plus offsets
	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			sx_s3 <= x_sel + HALF_W + {{16{pan_offsets[31]}}, pan_offsets[31:16]};
			sy_s3 <= y_sel + HALF_H + {{16{pan_offsets[15]}}, pan_offsets[15:0]};
			z_s3  <= z_s2;
		end
	end

	assign out_valid = v_s3;
	assign screen_x  = sx_s3;
	assign screen_y  = sy_s3;
	assign depth_z   = z_s3;

endmodule

`default_nettype wire

[hw/rtl/heightmap_point_transform.sv]
// Height-map point transform: scale, three rotations, optional isometric view, pan.
//
// Input channel in_valid/in_ready carries one grid point word (column, row,
// height_value). Output channel out_valid/out_ready carries one word per point
// (screen_x, screen_y, depth_z), in input order.
// Configuration channel cfg_valid/cfg_ready writes register cfg_index with
// cfg_data; cfg_ready is always high, unknown indexes are dropped. Write it only
// while no point is in flight.
// On the way to its output word a point passes the front end, the three rotation
// units (product stage, sum stage each) and the projection and pan unit.
// Throughput is one point per cycle while out_ready is high; each multiplier has
// its own pipeline stage and takes a new operand set every cycle unless held.
// Reset clears all valid bits and loads the register defaults (zoom 1, height
// scale 1, grid 1 by 1, identity rotations, no projection, no pan).
// When the receiver stalls, the last stage holds its word and earlier stages
// keep filling empty slots; in_ready drops only once every stage is full.
`default_nettype none

module heightmap_point_transform import hpt_pkg::*; #(
	parameter int SCREEN_WIDTH  = 1920,
	parameter int SCREEN_HEIGHT = 1080
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [11:0]        column,
	input  wire logic [11:0]        row,
	input  wire logic signed [15:0] height_value,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic signed [31:0] screen_x,
	output      logic signed [31:0] screen_y,
	output      logic signed [31:0] depth_z,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	logic [9:0]        zoom_q;
	logic signed [8:0] height_scale_q;
	logic [31:0]       grid_dims_q;
	logic [31:0]       trig_x_q, trig_y_q, trig_z_q;
	logic              iso_enable_q;
	logic [31:0]       pan_q;

	logic       fr_valid, fr_ready, rx_valid, rx_ready, ry_valid, ry_ready, rz_valid, rz_ready;
	hpt_coord_t fr_x, fr_y, fr_z;
	hpt_coord_t rx_a, rx_b, rx_p;
	hpt_coord_t ry_a, ry_b, ry_p;
	hpt_coord_t rz_a, rz_b, rz_p;

	logic signed [16:0] z_sin_neg;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q         <= 10'd1;
			height_scale_q <= 9'sd1;
			grid_dims_q    <= 32'h0001_0001;
			trig_x_q       <= 32'h4000_0000;
			trig_y_q       <= 32'h4000_0000;
			trig_z_q       <= 32'h4000_0000;
			iso_enable_q   <= 1'b0;
			pan_q          <= 32'h0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ZOOM:   zoom_q         <= cfg_data[9:0];
				CFG_HSCALE: height_scale_q <= cfg_data[8:0];
				CFG_GRID:   grid_dims_q    <= cfg_data;
				CFG_TRIG_X: trig_x_q       <= cfg_data;
				CFG_TRIG_Y: trig_y_q       <= cfg_data;
				CFG_TRIG_Z: trig_z_q       <= cfg_data;
				CFG_ISO:    iso_enable_q   <= cfg_data[0];
				CFG_PAN:    pan_q          <= cfg_data;
				default: ;
			endcase
		end
	end

	// scaling and centring
	hpt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.column       (column),
		.row          (row),
		.height_value (height_value),
		.zoom         (zoom_q),
		.height_scale (height_scale_q),
		.grid_dims    (grid_dims_q),
		.out_valid    (fr_valid),
		.out_ready    (fr_ready),
		.x_cen        (fr_x),
		.y_cen        (fr_y),
		.z_scaled     (fr_z)
	);

	// rotation about x acts on (y, z)
	hpt_rot u_rot_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.a         (fr_y),
		.b         (fr_z),
		.pass      (fr_x),
		.cos_q14   (trig_x_q[31:16]),
		.sin_q14   ({trig_x_q[15], trig_x_q[15:0]}),
		.out_valid (rx_valid),
		.out_ready (rx_ready),
		.a_rot     (rx_a),
		.b_rot     (rx_b),
		.pass_out  (rx_p)
	);

	// rotation about y acts on (x, z)
	hpt_rot u_rot_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx_valid),
		.in_ready  (rx_ready),
		.a         (rx_p),
		.b         (rx_b),
		.pass      (rx_a),
		.cos_q14   (trig_y_q[31:16]),
		.sin_q14   ({trig_y_q[15], trig_y_q[15:0]}),
		.out_valid (ry_valid),
		.out_ready (ry_ready),
		.a_rot     (ry_a),
		.b_rot     (ry_b),
		.pass_out  (ry_p)
	);

	// rotation about z turns the other way, so the sine is negated
	assign z_sin_neg = -$signed({trig_z_q[15], trig_z_q[15:0]});

	hpt_rot u_rot_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ry_valid),
		.in_ready  (ry_ready),
		.a         (ry_a),
		.b         (ry_p),
		.pass      (ry_b),
		.cos_q14   (trig_z_q[31:16]),
		.sin_q14   (z_sin_neg),
		.out_valid (rz_valid),
		.out_ready (rz_ready),
		.a_rot     (rz_a),
		.b_rot     (rz_b),
		.pass_out  (rz_p)
	);

	// projection, pan and output register
	hpt_proj #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_proj (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (rz_valid),
		.in_ready    (rz_ready),
		.x           (rz_a),
		.y           (rz_b),
		.z           (rz_p),
		.iso_enable  (iso_enable_q),
		.pan_offsets (pan_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.screen_x    (screen_x),
		.screen_y    (screen_y),
		.depth_z     (depth_z)
	);

	// input backpressure only when the whole pipe is full up to a held output
	a_full_before_block: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input blocked while output is empty");

	// the first rotation unit only refuses a word while holding one it cannot pass on
	a_rot_x_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!fr_ready |-> (rx_valid && !rx_ready))
		else $error("rotation unit blocked without a held word");

	// writes to unknown indexes leave the zoom, grid, z trig and pan registers alone
	a_cfg_unknown_index: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index > CFG_PAN) |=>
		($stable(zoom_q) && $stable(grid_dims_q) && $stable(trig_z_q) && $stable(pan_q)))
		else $error("unknown register index changed configuration");

endmodule

`default_nettype wire
